### sv/mtf_pkg.sv
// Shared types and constants for the move-to-front codec.
package mtf_pkg;

    // Width of one symbol or rank.
    localparam int SYM_W = 8;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_DIRECTION = 1'b0;

    // Coding directions.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef logic [SYM_W-1:0] sym_t;

    // Control broadcast from the sequencer to every cell of the list.
    typedef struct packed {
        logic cmp_en;
        logic dir;
        sym_t key;
        logic upd_en;
        logic hit;
        sym_t pos;
        logic clear;
    } mtf_ctrl_t;

endpackage

### sv/mtf_if.sv
// Stream interfaces for the input and output channels of the codec.
interface mtf_in_if import mtf_pkg::*; ();
    logic valid;
    logic ready;
    sym_t in_byte;
    logic block_last;

    modport source (output valid, output in_byte, output block_last, input ready);
    modport sink (input valid, input in_byte, input block_last, output ready);
endinterface

interface mtf_out_if import mtf_pkg::*; ();
    logic valid;
    logic ready;
    sym_t out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

### sv/mtf_cell.sv
// One list cell: holds a symbol, compares it and shifts from its neighbor.
module mtf_cell import mtf_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic      clk,
    input  logic      rst_n,
    input  mtf_ctrl_t ctrl,
    input  sym_t      shift_in,
    output sym_t      sym,
    output logic      match
);

    localparam sym_t IDX = SYM_W'(INDEX);

    sym_t sym_reg;
    logic match_reg;
    logic match_next;
    logic shift;

    // Encode matches on the stored symbol, decode matches on the position.
    assign match_next = (ctrl.dir == DIR_DECODE) ? (ctrl.key == IDX) : (sym_reg == ctrl.key);

    // Cells at or below the moved entry's old position take the left neighbor.
    assign shift = ctrl.upd_en && ctrl.hit && (IDX <= ctrl.pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg   <= IDX;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                match_reg <= match_next;
            end
            if (ctrl.clear)
            begin
                sym_reg <= IDX;
            end
            else if (shift)
            begin
                sym_reg <= shift_in;
            end
        end
    end

    assign sym   = sym_reg;
    assign match = match_reg;

endmodule

### sv/mtf_cfg.sv
// APB register block holding the coding direction.
module mtf_cfg import mtf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  direction
);

    logic direction_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);

    // Only bit 0 of the written word is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
        end
        else if (wr_en)
        begin
            direction_reg <= pwdata[0];
        end
    end

    // Read back the direction; other addresses read as zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DIRECTION)
        begin
            prdata[0] = direction_reg;
        end
    end

    assign direction = direction_reg;

endmodule

### sv/move_to_front_codec.sv
// Top level of the move-to-front codec: sequencer, cell chain and output register.
//
//   channel    role     payload                    handshake
//   data_in    sink     in_byte[7:0], block_last   valid / ready
//   data_out   source   out_byte[7:0]              valid / ready
//   apb        slave    direction (address 0)      psel / penable, pready = 1
//
// Each item passes through these steps in order: the cells compare on the accept edge, an OR tree
// over the cell chain reduces the match to a position and symbol, and then the
// chain shifts. A result waiting on a stalled data_out holds the shift step.
// Reset puts the list in identity order at once and sets direction to encode.
module move_to_front_codec import mtf_pkg::*; #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mtf_in_if.sink                data_in,
    mtf_out_if.source             data_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_UPDATE
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    sym_t      key_reg;
    logic      last_reg;
    sym_t      pos_reg;
    sym_t      msym_reg;
    logic      hit_reg;
    logic      out_valid_reg;
    sym_t      out_byte_reg;
    logic      direction;
    logic      accept;
    logic      upd_fire;
    sym_t      pos_red;
    sym_t      sym_red;
    logic      hit_red;
    sym_t      result;
    mtf_ctrl_t ctrl;

    sym_t                     cell_sym [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] cell_match;

    // Configuration registers.
    mtf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .direction (direction)
    );

    // Handshake and step enables.
    assign data_in.ready = (state_reg == ST_IDLE);
    assign accept        = data_in.valid && data_in.ready;
    assign upd_fire      = (state_reg == ST_UPDATE) && (!out_valid_reg || data_out.ready);

    // Control broadcast to the chain.
    always_comb
    begin
        ctrl.cmp_en = accept;
        ctrl.dir    = direction;
        ctrl.key    = data_in.in_byte;
        ctrl.upd_en = upd_fire;
        ctrl.hit    = hit_reg;
        ctrl.pos    = pos_reg;
        ctrl.clear  = upd_fire && last_reg;
    end

    // The chain of cells; cell 0 takes the moved symbol.
    for (genvar k = 0; k < ALPHABET_SIZE; k++)
    begin : g_cell
        sym_t shift_in;
        if (k == 0)
        begin : g_head
            assign shift_in = msym_reg;
        end
        else
        begin : g_body
            assign shift_in = cell_sym[k-1];
        end
        mtf_cell #(
            .INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (shift_in),
            .sym      (cell_sym[k]),
            .match    (cell_match[k])
        );
    end

    // OR tree over the one-hot match: position and symbol of the hit.
    always_comb
    begin
        pos_red = '0;
        sym_red = '0;
        for (int k = 0; k < ALPHABET_SIZE; k++)
        begin
            pos_red = pos_red | (SYM_W'(k) & {SYM_W{cell_match[k]}});
            sym_red = sym_red | (cell_sym[k] & {SYM_W{cell_match[k]}});
        end
        hit_red = |cell_match;
    end

    // A miss passes the input byte through unchanged.
    assign result = !hit_reg ? key_reg : ((direction == DIR_DECODE) ? msym_reg : pos_reg);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (data_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= data_in.in_byte;
            last_reg <= data_in.block_last;
        end
        if (state_reg == ST_REDUCE)
        begin
            pos_reg  <= pos_red;
            msym_reg <= sym_red;
            hit_reg  <= hit_red;
        end
        if (upd_fire)
        begin
            out_byte_reg <= result;
        end
    end

    assign data_out.valid    = out_valid_reg;
    assign data_out.out_byte = out_byte_reg;

endmodule

### sv/mtf_checker.sv
// Port-level checker for the move-to-front codec and its bind.
module mtf_checker import mtf_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input sym_t out_byte,
    input logic pready
);

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("output byte changed while stalled");

    // An accepted byte keeps the input blocked through the reduce and update states.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input accepted while a byte is in flight");

    // A new result appears only at the end of a busy interval.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result produced without an item in flight");

    // The register port never waits.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready deasserted");

endmodule

bind move_to_front_codec mtf_checker u_mtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_in.valid),
    .in_ready  (data_in.ready),
    .out_valid (data_out.valid),
    .out_ready (data_out.ready),
    .out_byte  (data_out.out_byte),
    .pready    (pready)
);

### tb/sv/move_to_front_codec_test.sv
// Self-checking testbench for the move-to-front codec: random streams against a list predictor.
`timescale 1ns / 1ps

module move_to_front_codec_test;
    import mtf_pkg::*;

    localparam int ALPHABET = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASE_ITEMS = 72;

    // Predicts codec results from its own copy of the symbol list and direction.
    class mtf_scoreboard;
        sym_t order[ALPHABET];
        logic dir;
        sym_t pending[$];
        int mismatches;
        int checked;
        int encoded;
        int decoded;

        function new();
            restore_identity();
            dir = DIR_ENCODE;
        endfunction

        function void restore_identity();
            for (int i = 0; i < ALPHABET; i++)
                order[i] = sym_t'(i);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        // Works out the result of one accepted transfer and updates the list.
        function void note_input(sym_t b, logic last);
            int pos;
            sym_t sym;
            sym_t want;
            pos = -1;
            want = b;
            if (dir == DIR_ENCODE) begin
                encoded++;
                for (int j = 0; j < ALPHABET; j++)
                    if (pos < 0 && order[j] == b)
                        pos = j;
                if (pos >= 0)
                    want = sym_t'(pos);
            end
            else begin
                decoded++;
                if (int'(b) < ALPHABET) begin
                    pos = int'(b);
                    want = order[pos];
                end
            end
            // The symbol found moves to the front; entries in front of it shift back one place.
            if (pos >= 0) begin
                sym = order[pos];
                for (int k = pos; k > 0; k--)
                    order[k] = order[k - 1];
                order[0] = sym;
            end
            if (last)
                restore_identity();
            pending.push_back(want);
        endfunction

        function void check_result(sym_t got);
            sym_t want;
            if (pending.size() == 0) begin
                flag($sformatf("out_byte %0d with no result pending", got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
                flag($sformatf("out_byte expected %0d, got %0d", want, got));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    mtf_in_if in_ch ();
    mtf_out_if out_ch ();

    mtf_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_requests;
    int hold_off_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int block_ends = 0;
    int dir_writes;
    sym_t recent[8];

    move_to_front_codec #(.ALPHABET_SIZE(ALPHABET)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .data_in(in_ch),
        .data_out(out_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output transfers are checked before the input transfer of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_byte);
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.in_byte, in_ch.block_last);
                if (in_ch.block_last)
                    block_ends++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_requests;
            hold_left <= HOLD_OFF_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run after too many cycles with no transfer of any kind.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("move_to_front_codec_test failed");
                $finish;
            end
        end
    end

    // One APB access: setup, access until pready, then idle with psel low.
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drops valid, waits for every pending result, then lets the chain settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the direction register with junk in the unused bits, then reads it back.
    task automatic set_direction(input logic d);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rdata;
        wait_idle();
        wdata = {$urandom()} & ~APB_DATA_W'(1);
        wdata[0] = d;
        apb_access(1'b1, {REG_DIRECTION, 2'b00}, wdata, rdata);
        sb.dir = d;
        dir_writes++;
        apb_access(1'b0, {REG_DIRECTION, 2'b00}, '0, rdata);
        if (rdata[0] !== d)
            sb.flag($sformatf("direction readback expected %0d, got %0d", d, rdata[0]));
    endtask

    // Offers one byte after a random gap and returns once it is accepted.
    task automatic send_byte(input sym_t b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.block_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        recent[$urandom_range(7)] = b;
    endtask

    // Random blocks: repeated symbols or small ranks dominate so that the list churns.
    task automatic run_random(input int n, input bit pressure);
        int sent;
        int len;
        int r;
        sym_t b;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            if (len > n - sent)
                len = n - sent;
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(99);
                if (r < 50)
                    b = (sb.dir == DIR_ENCODE) ? recent[$urandom_range(7)]
                                               : sym_t'($urandom_range(3));
                else if (r < 60)
                    b = ($urandom_range(1) != 0) ? sym_t'(ALPHABET - 1) : sym_t'(0);
                else
                    b = sym_t'($urandom_range(255));
                if (pressure && sent == 10)
                    hold_off_requests <= hold_off_requests + 1;
                send_byte(b, (i == len - 1) || ($urandom_range(99) == 0));
                sent++;
            end
        end
    endtask

    // Directed bytes: extremes, repeats and block ends, first encoding then decoding.
    sym_t directed_bytes[16] = '{8'd255, 8'd255, 8'd0, 8'd128, 8'd0, 8'd1, 8'd255, 8'd0,
                                 8'd255, 8'd0, 8'd1, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0};
    logic directed_last[16] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                                1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.block_last <= 1'b0;
        hold_off_requests = 0;
        dir_writes = 0;
        for (int i = 0; i < 8; i++)
            recent[i] = sym_t'($urandom_range(255));
        send_idle_pct = 7;
        recv_idle_pct = 74;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_direction(DIR_ENCODE);
        for (int i = 0; i < 16; i++) begin
            if (i == 8)
                set_direction(DIR_DECODE);
            send_byte(directed_bytes[i], directed_last[i]);
        end

        // Sender idles lightly, receiver heavily.
        set_direction(DIR_ENCODE);
        run_random(PHASE_ITEMS, 1'b0);
        set_direction(DIR_DECODE);
        run_random(PHASE_ITEMS, 1'b0);

        // Roles swapped.
        send_idle_pct = 74;
        recv_idle_pct = 7;
        set_direction(DIR_ENCODE);
        run_random(PHASE_ITEMS, 1'b0);
        set_direction(DIR_DECODE);
        run_random(PHASE_ITEMS, 1'b0);

        // No idling, with one long receiver hold-off per run to back up the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS, 1'b1);
        set_direction(DIR_ENCODE);
        run_random(PHASE_ITEMS, 1'b1);

        wait_idle();
        $display("Run covered %0d encoded and %0d decoded bytes in %0d blocks,",
                 sb.encoded, sb.decoded, block_ends);
        $display("%0d results checked, direction written %0d times, %0d hold-offs, %0d mismatches.",
                 sb.checked, dir_writes, hold_off_requests, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("move_to_front_codec_test passed");
        else
            $display("move_to_front_codec_test failed");
        $finish;
    end

endmodule

### move_to_front_codec.f
sv/mtf_pkg.sv
sv/mtf_if.sv
sv/mtf_cell.sv
sv/mtf_cfg.sv
sv/move_to_front_codec.sv
sv/mtf_checker.sv
tb/sv/move_to_front_codec_test.sv
